// File: hdl/mx3_pkg.sv
// Package for the 3x3 matrix arithmetic unit.
// Holds opcodes, status codes, state and select types and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mx3_pkg;

    localparam int ACC_W = 100;

    localparam logic [3:0] OP_LOAD_A = 4'd0;
    localparam logic [3:0] OP_LOAD_B = 4'd1;
    localparam logic [3:0] OP_ADD    = 4'd2;
    localparam logic [3:0] OP_SUB    = 4'd3;
    localparam logic [3:0] OP_MUL    = 4'd4;
    localparam logic [3:0] OP_SCALE  = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_DET    = 4'd7;
    localparam logic [3:0] OP_INV    = 4'd8;

    localparam logic [3:0] LAST_ELEM = 4'd8;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SING = 2'd1,
        ST_DIV0 = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        X_A   = 2'd0,
        X_TLO = 2'd1,
        X_THI = 2'd2,
        X_ONE = 2'd3
    } t_xsel;

    typedef enum logic [1:0] {
        Y_A   = 2'd0,
        Y_B   = 2'd1,
        Y_S   = 2'd2,
        Y_ONE = 2'd3
    } t_ysel;

    typedef enum logic [1:0] {
        O_ACC0  = 2'd0,
        O_ACCF  = 2'd1,
        O_ACC2F = 2'd2,
        O_DIV   = 2'd3
    } t_osel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_DCLR,
        S_DTRD,
        S_DTMUL,
        S_DTLD,
        S_DLMUL,
        S_DLACC,
        S_DHMUL,
        S_DHACC,
        S_DEND,
        S_SING,
        S_ECLR,
        S_ERD,
        S_EMUL,
        S_EACC,
        S_DIVGO,
        S_DIVW,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic       wr_a;
        logic       wr_b;
        logic [3:0] wr_idx;
        logic       scal_load;
        logic [3:0] ix;
        logic [3:0] iy;
        t_xsel      xsel;
        t_ysel      ysel;
        logic       acc_clr;
        logic       acc_en;
        logic       acc_neg;
        logic       acc_sh32;
        logic       t_load;
        logic       d_load;
        logic       div_start;
        logic       div_inv;
        logic       out_load;
        t_osel      osel;
        logic [3:0] out_idx;
        logic       out_last;
        logic       out_force;
        t_status    force_st;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic scal_zero;
        logic singular;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/mx3_div.sv
// Restoring divider producing one quotient bit per cycle on magnitudes.
// Depends on mx3_pkg only for house consistency of types.
`timescale 1ns / 1ps
`default_nettype none

module mx3_div
    import mx3_pkg::*;
#(
    parameter int NUM_W = 98,
    parameter int DEN_W = 100
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic [NUM_W-1:0]        o_quot,
    output logic                    o_neg
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;

    logic [DEN_W:0]   w_rem;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;
    logic [NUM_W-1:0] w_num_mag;
    logic [DEN_W-1:0] w_den_mag;

    assign w_num_mag = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
    assign w_den_mag = i_den[DEN_W-1] ? (~i_den + DEN_W'(1)) : i_den;
    assign w_rem     = {r_rem, r_num[NUM_W-1]};
    assign w_diff    = w_rem - {1'b0, r_den};
    assign w_ge      = w_rem >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_num_mag;
            r_den <= w_den_mag;
            r_rem <= '0;
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_neg  = r_neg;

endmodule

`default_nettype wire

// File: hdl/mx3_dp.sv
// Datapath: matrix stores, shared multiplier, accumulator, divider and output register.
// Depends on mx3_pkg and mx3_div.
`timescale 1ns / 1ps
`default_nettype none

module mx3_dp
    import mx3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_operand,
    input  logic               i_cfg_valid,
    input  logic [30:0]        i_cfg_data,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_out_value,
    output logic [3:0]         o_out_idx,
    output logic               o_out_last,
    output t_status            o_out_status
);

    localparam int NUM_W = 66 + 2 * FRAC_BITS;

    logic signed [31:0]      r_mem_a [0:8];
    logic signed [31:0]      r_mem_b [0:8];
    logic signed [31:0]      r_xa;
    logic signed [31:0]      r_ya;
    logic signed [31:0]      r_yb;
    logic signed [31:0]      r_scal;
    logic [30:0]             r_thr;
    logic signed [65:0]      r_prod;
    logic signed [63:0]      r_t;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_d;
    logic                    r_out_valid;
    logic [31:0]             r_out_value;
    logic [3:0]              r_out_idx;
    logic                    r_out_last;
    t_status                 r_out_status;

    logic signed [32:0]      w_x;
    logic signed [32:0]      w_y;
    logic signed [ACC_W-1:0] w_add;
    logic signed [ACC_W-1:0] w_add_sh;
    logic [ACC_W-1:0]        w_dmag;
    logic [ACC_W-1:0]        w_thr;
    logic signed [NUM_W-1:0] w_num;
    logic signed [ACC_W-1:0] w_den;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quot;
    logic                    w_neg;
    logic                    w_qsat;
    logic [31:0]             w_qval;
    logic [32:0]             w_sel;

    function automatic logic [32:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic ok;
        ok = (&v[ACC_W-1:31]) | ~(|v[ACC_W-1:31]);
        if (ok) begin
            return {1'b0, v[31:0]};
        end else if (v[ACC_W-1]) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b1, 32'h7FFF_FFFF};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_cmd.wr_idx] <= i_operand;
        end
        if (i_cmd.wr_b) begin
            r_mem_b[i_cmd.wr_idx] <= i_operand;
        end
        r_xa <= r_mem_a[i_cmd.ix];
        r_ya <= r_mem_a[i_cmd.iy];
        r_yb <= r_mem_b[i_cmd.iy];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_comb begin
        case (i_cmd.xsel)
            X_A:     w_x = {r_xa[31], r_xa};
            X_TLO:   w_x = {1'b0, r_t[31:0]};
            X_THI:   w_x = {r_t[63], r_t[63:32]};
            default: w_x = 33'sd1;
        endcase
        case (i_cmd.ysel)
            Y_A:     w_y = {r_ya[31], r_ya};
            Y_B:     w_y = {r_yb[31], r_yb};
            Y_S:     w_y = {r_scal[31], r_scal};
            default: w_y = 33'sd1;
        endcase
    end

    assign w_add    = ACC_W'(r_prod);
    assign w_add_sh = i_cmd.acc_sh32 ? (w_add <<< 32) : w_add;

    always_ff @(posedge i_clk) begin
        r_prod <= w_x * w_y;
        if (i_cmd.scal_load) begin
            r_scal <= i_operand;
        end
        if (i_cmd.t_load) begin
            r_t <= r_prod[63:0];
        end
        if (i_cmd.d_load) begin
            r_d <= r_acc;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_neg ? (r_acc - w_add_sh) : (r_acc + w_add_sh);
        end
    end

    assign w_dmag = r_d[ACC_W-1] ? (~r_d + ACC_W'(1)) : r_d;
    assign w_thr  = ACC_W'(r_thr) << (2 * FRAC_BITS);
    assign w_num  = NUM_W'(r_acc) <<< (i_cmd.div_inv ? 2 * FRAC_BITS : FRAC_BITS);
    assign w_den  = i_cmd.div_inv ? r_d : ACC_W'(r_scal);

    mx3_div #(
        .NUM_W(NUM_W),
        .DEN_W(ACC_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_quot),
        .o_neg  (w_neg)
    );

    always_comb begin
        if (w_neg) begin
            w_qsat = (|w_quot[NUM_W-1:32]) | (w_quot[31] & (|w_quot[30:0]));
            w_qval = w_qsat ? 32'h8000_0000 : (~w_quot[31:0] + 32'd1);
        end else begin
            w_qsat = (|w_quot[NUM_W-1:32]) | w_quot[31];
            w_qval = w_qsat ? 32'h7FFF_FFFF : w_quot[31:0];
        end
        case (i_cmd.osel)
            O_ACC0:  w_sel = sat_acc(r_acc);
            O_ACCF:  w_sel = sat_acc(r_acc >>> FRAC_BITS);
            O_ACC2F: w_sel = sat_acc(r_acc >>> (2 * FRAC_BITS));
            default: w_sel = {w_qsat, w_qval};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= i_cmd.out_idx;
            r_out_last <= i_cmd.out_last;
            if (i_cmd.out_force) begin
                r_out_value  <= '0;
                r_out_status <= i_cmd.force_st;
            end else begin
                r_out_value  <= w_sel[31:0];
                r_out_status <= w_sel[32] ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.scal_zero = (r_scal == 32'sd0);
    assign o_stat.singular  = (w_dmag <= w_thr);

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_idx    = r_out_idx;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

// File: hdl/mx3_ctrl.sv
// Controller state machine that sequences loads, products, accumulation and division.
// Depends on mx3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mx3_ctrl
    import mx3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_op,
    input  logic [3:0] i_elem_index,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] COF_TAB [0:8][0:3] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    t_state     r_state, n_state;
    logic [3:0] r_op, n_op;
    logic [3:0] r_i, n_i;
    logic [1:0] r_k, n_k;
    logic [1:0] r_j, n_j;
    logic       r_h, n_h;

    logic [3:0] w_drow;
    logic       w_last_k;
    logic       w_last_e;

    function automatic logic [3:0] row_base(input logic [3:0] idx);
        case (idx) inside
            4'd0, 4'd1, 4'd2: return 4'd0;
            4'd3, 4'd4, 4'd5: return 4'd3;
            default:          return 4'd6;
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LOAD_A;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_h     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
            r_h     <= n_h;
        end
    end

    assign w_drow   = 4'({2'b00, r_j} * 4'd3);
    assign w_last_e = (r_op == OP_DET) || (r_i == LAST_ELEM);

    always_comb begin
        unique case (r_op)
            OP_MUL:                 w_last_k = (r_k == 2'd2);
            OP_ADD, OP_SUB, OP_INV: w_last_k = (r_k == 2'd1);
            default:                w_last_k = (r_k == 2'd0);
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_i        = r_i;
        n_k        = r_k;
        n_j        = r_j;
        n_h        = r_h;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.wr_idx   = i_elem_index;
        o_cmd.div_inv  = (r_op == OP_INV);
        o_cmd.out_idx  = r_i;
        o_cmd.out_last = w_last_e;
        o_cmd.force_st = (r_op == OP_DIV) ? ST_DIV0 : ST_SING;
        unique case (r_op)
            OP_ADD, OP_SUB:   o_cmd.osel = O_ACC0;
            OP_MUL, OP_SCALE: o_cmd.osel = O_ACCF;
            OP_DET:           o_cmd.osel = O_ACC2F;
            default:          o_cmd.osel = O_DIV;
        endcase

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.scal_load = 1'b1;
                    o_cmd.wr_a = (i_op == OP_LOAD_A) && (i_elem_index <= LAST_ELEM);
                    o_cmd.wr_b = (i_op == OP_LOAD_B) && (i_elem_index <= LAST_ELEM);
                    n_op = i_op;
                    if (i_op >= OP_ADD && i_op <= OP_INV) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_i = '0;
                n_k = '0;
                n_j = '0;
                n_h = 1'b0;
                if (r_op == OP_DIV && i_stat.scal_zero) begin
                    n_state = S_ERR;
                end else if (r_op == OP_DET || r_op == OP_INV) begin
                    n_state = S_DCLR;
                end else begin
                    n_state = S_ECLR;
                end
            end
            S_DCLR: begin
                o_cmd.acc_clr = 1'b1;
                n_state = S_DTRD;
            end
            S_DTRD: begin
                o_cmd.ix = COF_TAB[w_drow][{r_h, 1'b0}];
                o_cmd.iy = COF_TAB[w_drow][{r_h, 1'b1}];
                n_state = S_DTMUL;
            end
            S_DTMUL: begin
                o_cmd.xsel = X_A;
                o_cmd.ysel = Y_A;
                o_cmd.iy   = {2'b00, r_j};
                n_state = S_DTLD;
            end
            S_DTLD: begin
                o_cmd.t_load = 1'b1;
                o_cmd.iy     = {2'b00, r_j};
                n_state = S_DLMUL;
            end
            S_DLMUL: begin
                o_cmd.xsel = X_TLO;
                o_cmd.ysel = Y_A;
                o_cmd.iy   = {2'b00, r_j};
                n_state = S_DLACC;
            end
            S_DLACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_neg = r_h;
                o_cmd.iy      = {2'b00, r_j};
                n_state = S_DHMUL;
            end
            S_DHMUL: begin
                o_cmd.xsel = X_THI;
                o_cmd.ysel = Y_A;
                n_state = S_DHACC;
            end
            S_DHACC: begin
                o_cmd.acc_en   = 1'b1;
                o_cmd.acc_neg  = r_h;
                o_cmd.acc_sh32 = 1'b1;
                if (!r_h) begin
                    n_h = 1'b1;
                    n_state = S_DTRD;
                end else begin
                    n_h = 1'b0;
                    if (r_j == 2'd2) begin
                        n_state = S_DEND;
                    end else begin
                        n_j = r_j + 2'd1;
                        n_state = S_DTRD;
                    end
                end
            end
            S_DEND: begin
                if (r_op == OP_DET) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.d_load = 1'b1;
                    n_state = S_SING;
                end
            end
            S_SING: begin
                n_state = i_stat.singular ? S_ERR : S_ECLR;
            end
            S_ECLR: begin
                o_cmd.acc_clr = 1'b1;
                n_k = '0;
                n_state = S_ERD;
            end
            S_ERD: begin
                unique case (r_op)
                    OP_MUL: begin
                        o_cmd.ix = row_base(r_i) + {2'b00, r_k};
                        o_cmd.iy = 4'({2'b00, r_k} * 4'd3) + (r_i - row_base(r_i));
                    end
                    OP_INV: begin
                        o_cmd.ix = COF_TAB[r_i][{r_k[0], 1'b0}];
                        o_cmd.iy = COF_TAB[r_i][{r_k[0], 1'b1}];
                    end
                    default: begin
                        o_cmd.ix = r_i;
                        o_cmd.iy = r_i;
                    end
                endcase
                n_state = S_EMUL;
            end
            S_EMUL: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        o_cmd.xsel = (r_k == 2'd0) ? X_A : X_ONE;
                        o_cmd.ysel = (r_k == 2'd0) ? Y_ONE : Y_B;
                    end
                    OP_MUL: begin
                        o_cmd.xsel = X_A;
                        o_cmd.ysel = Y_B;
                    end
                    OP_SCALE: begin
                        o_cmd.xsel = X_A;
                        o_cmd.ysel = Y_S;
                    end
                    OP_INV: begin
                        o_cmd.xsel = X_A;
                        o_cmd.ysel = Y_A;
                    end
                    default: begin
                        o_cmd.xsel = X_A;
                        o_cmd.ysel = Y_ONE;
                    end
                endcase
                n_state = S_EACC;
            end
            S_EACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_neg = (r_op == OP_SUB || r_op == OP_INV) && (r_k == 2'd1);
                if (w_last_k) begin
                    n_state = (r_op == OP_DIV || r_op == OP_INV) ? S_DIVGO : S_EMIT;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_ERD;
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (w_last_e) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + 4'd1;
                        n_state = S_ECLR;
                    end
                end
            end
            S_ERR: begin
                o_cmd.out_idx   = '0;
                o_cmd.out_last  = 1'b1;
                o_cmd.out_force = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/matrix3x3_arithmetic_unit.sv
// Top level of the 3x3 matrix arithmetic unit on signed fixed point.
// Depends on mx3_pkg, mx3_ctrl and mx3_dp.
//
// Channel   Direction  Signals                     Payload
// s_axis    in         tvalid tready tdata[39:0]   op, elem_index, operand_value
// m_axis    out        tvalid tready tdata[39:0]   result_value, result_index; tlast; tuser status
// cfg       in         valid ready data[30:0]      singular_threshold
//
// Add, sub, scale and the other divide-free paths run per element through the one shared
// 33x33 multiplier. Divide and inverse run each element through the bit-serial divider,
// and inverse also computes the determinant first.
// Reset is synchronous and clears the controller, the output valid and the threshold.
// A stalled output holds the controller only when the next result is ready to be written.
`timescale 1ns / 1ps
`default_nettype none

module matrix3x3_arithmetic_unit
    import mx3_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: op[3:0], elem_index[7:4], operand_value[39:8].
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: result_value[31:0], result_index[35:32], zero fill[39:36].
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    t_dp_cmd     w_cmd;
    t_dp_stat    w_stat;
    logic [31:0] w_value;
    logic [3:0]  w_idx;
    t_status     w_status;

    mx3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_op        (i_s_axis_tdata[3:0]),
        .i_elem_index(i_s_axis_tdata[7:4]),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mx3_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_operand   ($signed(i_s_axis_tdata[39:8])),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_value (w_value),
        .o_out_idx   (w_idx),
        .o_out_last  (o_m_axis_tlast),
        .o_out_status(w_status)
    );

    assign o_m_axis_tdata = {4'd0, w_idx, w_value};
    assign o_m_axis_tuser = w_status;
    assign o_cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// File: hdl/mx3_chk.sv
// Port-level checker for the 3x3 matrix arithmetic unit, bound to the top level.
// Depends on mx3_pkg for opcodes and status codes.
`timescale 1ns / 1ps
`default_nettype none

module mx3_chk
    import mx3_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [30:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Stalled result transaction changed.");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_SING || o_m_axis_tuser == ST_DIV0) |->
            o_m_axis_tlast && (o_m_axis_tdata[35:0] == 36'd0))
        else $error("Error result transaction is not a single zero item.");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |->
            (o_m_axis_tdata[35:32] == 4'd0) || (o_m_axis_tdata[35:32] == LAST_ELEM))
        else $error("Final result transaction has an unexpected index.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata[3:0] >= OP_ADD) &&
            (i_s_axis_tdata[3:0] <= OP_INV) |=> !o_s_axis_tready)
        else $error("Input taken while a command is in progress.");

endmodule

bind matrix3x3_arithmetic_unit mx3_chk u_mx3_chk (.*);

`default_nettype wire

// File: tb/tb_matrix3x3_arithmetic_unit.sv
// Self-checking testbench for the 3x3 matrix arithmetic unit.
// It drives command transactions, predicts each result at full width and compares them in order.
// Depends on mx3_pkg and matrix3x3_arithmetic_unit.
`timescale 1ns / 1ps

module tb_matrix3x3_arithmetic_unit;
    import mx3_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int IDLE_PCT   = 19;
    localparam int SETTLE     = 300;
    localparam int HOLD_LEN   = 400;
    localparam int STALL_MAX  = 20000;
    localparam logic signed [127:0] MAX_V = 128'sh7fffffff;
    localparam logic signed [127:0] MIN_V = ~MAX_V;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        last;
        t_status     status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;

    matrix3x3_arithmetic_unit #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    logic signed [31:0] mat_a [9];
    logic signed [31:0] mat_b [9];
    logic [30:0]        threshold;
    t_result            pending_results[$];
    int                 errors;
    int                 results_seen;
    int                 commands_sent;
    int                 inverses_sent;
    int                 idle_en;
    int                 hold_req;
    int                 hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] wide(input logic signed [31:0] x);
        return x;
    endfunction

    function automatic logic signed [127:0] cofactor(input int i);
        logic [15:0] t;
        case (i)
            0: t = 16'h4857;
            1: t = 16'h2718;
            2: t = 16'h1524;
            3: t = 16'h5638;
            4: t = 16'h0826;
            5: t = 16'h2305;
            6: t = 16'h3746;
            7: t = 16'h1607;
            default: t = 16'h0413;
        endcase
        return wide(mat_a[t[15:12]]) * wide(mat_a[t[11:8]])
             - wide(mat_a[t[7:4]]) * wide(mat_a[t[3:0]]);
    endfunction

    function automatic logic signed [127:0] determinant();
        return wide(mat_a[0]) * cofactor(0) + wide(mat_a[1]) * cofactor(3)
             + wide(mat_a[2]) * cofactor(6);
    endfunction

    task automatic push_result(input logic signed [127:0] v, input int i, input logic last);
        t_result r;
        r.index = 4'(i);
        r.last = last;
        r.status = ST_OK;
        if (v > MAX_V) begin
            r.value = 32'h7fffffff;
            r.status = ST_SAT;
        end else if (v < MIN_V) begin
            r.value = 32'h80000000;
            r.status = ST_SAT;
        end else begin
            r.value = v[31:0];
        end
        pending_results.push_back(r);
    endtask

    task automatic push_fault(input t_status st);
        t_result r;
        r.value = '0;
        r.index = '0;
        r.last = 1'b1;
        r.status = st;
        pending_results.push_back(r);
    endtask

    task automatic predict_command(input logic [3:0] op, input logic [3:0] idx,
                                   input logic signed [31:0] val);
        logic signed [127:0] v;
        logic signed [127:0] s;
        logic signed [127:0] det;
        logic signed [127:0] mag;
        logic signed [127:0] thr;
        s = wide(val);
        if (op == OP_LOAD_A || op == OP_LOAD_B) begin
            if (idx <= LAST_ELEM) begin
                if (op == OP_LOAD_A) mat_a[idx] = val;
                else mat_b[idx] = val;
            end
            return;
        end
        if (op > OP_INV) return;
        if (op == OP_DIV && val == 0) begin
            push_fault(ST_DIV0);
            return;
        end
        det = determinant();
        if (op == OP_DET) begin
            push_result(det >>> (2 * FRAC_BITS), 0, 1'b1);
            return;
        end
        if (op == OP_INV) begin
            mag = det < 0 ? -det : det;
            thr = wide({1'b0, threshold}) <<< (2 * FRAC_BITS);
            if (thr >= mag) begin
                push_fault(ST_SING);
                return;
            end
        end
        for (int i = 0; i < 9; i++) begin
            case (op)
                OP_ADD: v = wide(mat_a[i]) + wide(mat_b[i]);
                OP_SUB: v = wide(mat_a[i]) - wide(mat_b[i]);
                OP_MUL: begin
                    v = 0;
                    for (int k = 0; k < 3; k++)
                        v = v + wide(mat_a[(i / 3) * 3 + k]) * wide(mat_b[k * 3 + i % 3]);
                    v = v >>> FRAC_BITS;
                end
                OP_SCALE: v = (wide(mat_a[i]) * s) >>> FRAC_BITS;
                OP_DIV: v = (wide(mat_a[i]) <<< FRAC_BITS) / s;
                default: v = (cofactor(i) <<< (2 * FRAC_BITS)) / det;
            endcase
            push_result(v, i, i == 8);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $time);
        errors++;
    endtask

    // Result checker: every output transaction is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 32'h0, o_m_axis_tdata[31:0]);
            end else begin
                e = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== e.value)
                    report_mismatch("value", e.value, o_m_axis_tdata[31:0]);
                if (o_m_axis_tdata[35:32] !== e.index)
                    report_mismatch("index", 32'(e.index), 32'(o_m_axis_tdata[35:32]));
                if (o_m_axis_tdata[39:36] !== 4'h0)
                    report_mismatch("fill", 32'h0, 32'(o_m_axis_tdata[39:36]));
                if (o_m_axis_tlast !== e.last)
                    report_mismatch("last", 32'(e.last), 32'(o_m_axis_tlast));
                if (o_m_axis_tuser !== e.status)
                    report_mismatch("status", 32'(e.status), 32'(o_m_axis_tuser));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_en) begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                stall = 0;
            else
                stall++;
            if (stall >= STALL_MAX) begin
                $display("timeout: no transaction for %0d cycles", STALL_MAX);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [3:0] op, input logic [3:0] idx,
                             input logic [31:0] val);
        if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {val, idx, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_command(op, idx, val);
        if (op >= OP_ADD && op <= OP_INV) commands_sent++;
        if (op == OP_INV) inverses_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        threshold = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2, 3: return $urandom;
            4: return 32'h0;
            default: return {{14{$urandom_range(0, 1) == 1}}, 2'($urandom_range(0, 3)),
                             16'($urandom)};
        endcase
    endfunction

    task automatic test_directed_ops();
        logic [31:0] a_vals [9];
        a_vals = '{32'h7fffffff, 32'h00010000, 32'h80000000, 32'h00000000, 32'h00020000,
                   32'hfffe8000, 32'h00008000, 32'h00000001, 32'h00030000};
        for (int i = 0; i < 9; i++) send_item(OP_LOAD_A, 4'(i), a_vals[i]);
        for (int i = 0; i < 9; i++)
            send_item(OP_LOAD_B, 4'(i), i[0] ? 32'h80000000 : 32'h7fffffff - 32'(i));
        send_item(OP_ADD, 4'd0, 32'h0);
        send_item(OP_SUB, 4'd15, 32'hffffffff);
        send_item(OP_MUL, 4'd0, 32'h0);
        send_item(OP_SCALE, 4'd0, 32'h7fffffff);
        send_item(OP_SCALE, 4'd0, 32'h80000000);
        send_item(OP_DIV, 4'd0, 32'h0);
        send_item(OP_DIV, 4'd0, 32'hffffffff);
        send_item(OP_DET, 4'd0, 32'h0);
        send_item(OP_INV, 4'd0, 32'h0);
        send_item(OP_LOAD_A, 4'd15, 32'h12345678);
        send_item(4'd15, 4'd9, 32'hdeadbeef);
        drain();
    endtask

    task automatic test_singular();
        write_threshold(31'h7fffffff);
        send_item(OP_INV, 4'd0, 32'h0);
        send_item(OP_LOAD_A, 4'd0, 32'h00010000);
        send_item(OP_INV, 4'd0, 32'h0);
        drain();
        write_threshold(31'd0);
        for (int i = 0; i < 3; i++) send_item(OP_LOAD_A, 4'(i), 32'h0);
        send_item(OP_DET, 4'd0, 32'h0);
        send_item(OP_INV, 4'd0, 32'h0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 6; i++)
            send_item(4'($urandom_range(OP_ADD, OP_SCALE)), 4'($urandom), random_operand());
        drain();
    endtask

    task automatic test_random(input int count);
        int done;
        logic [3:0] op;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 99) < 70) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                              4'($urandom_range(0, 8)), random_operand());
                    done++;
                end
                op = 4'($urandom_range(OP_ADD, OP_INV));
                send_item(op, 4'($urandom), op == OP_DIV && $urandom_range(0, 4) == 0
                          ? 32'h0 : random_operand());
                done++;
            end else begin
                op = 4'($urandom);
                if (op <= OP_LOAD_B) send_item(op, 4'($urandom_range(9, 15)), $urandom);
                else send_item(4'($urandom_range(9, 15)), 4'($urandom), $urandom);
                done++;
            end
        end
        drain();
    endtask

    initial begin
        errors = 0;
        results_seen = 0;
        commands_sent = 0;
        inverses_sent = 0;
        idle_en = 1;
        hold_req = 0;
        hold_left = 0;
        threshold = '0;
        for (int i = 0; i < 9; i++) begin
            mat_a[i] = '0;
            mat_b[i] = '0;
        end
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_threshold(31'd0);
        test_directed_ops();
        test_singular();
        test_backpressure();
        idle_en = 0;
        test_random(22);
        idle_en = 1;
        write_threshold(31'($urandom_range(1, 4)));
        test_random(23);
        write_threshold(31'd0);
        test_random(22);

        $display("Covered %0d commands (%0d inverses) and %0d results over three threshold values.",
                 commands_sent, inverses_sent, results_seen);
        $display("Included saturation, divide by zero, singular inverse and output back-pressure.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
